>>> src/spmd_pkg.sv
// Package for the segment pair distance block: widths, word types and codes.
// Shared by spmd_front, spmd_back, spmd_outq and segment_pair_min_distance.
// No dependencies.
package spmd_pkg;

    localparam int COORD_W     = 32;
    localparam int DIST_W      = 33;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int MUL_W       = DIFF_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RF_W        = 2 * COORD_W + 4;
    localparam int NUM_W       = 2 * RF_W;
    localparam int ROOT_W      = NUM_W + 4;
    localparam int ROOT_SH     = 2 * (DIST_W - 1);
    localparam int SQ_HI_SH    = 2 * MUL_W;
    localparam int SQ_MID_SH   = MUL_W + 1;
    localparam int NUM_OPS     = 28;
    localparam int OP_CW       = 5;
    localparam int RF_N        = 14;
    localparam int RF_AW       = 4;
    localparam int CROSS_TOL_W = 32;
    localparam int COORD_TOL_W = 16;
    localparam int ZT_W        = 16;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 32;
    localparam int BIT_CW      = 6;

    localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_AW-1:0] CFG_CROSS_TOL   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COORD_TOL   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ZERO_THRESH = 2'd2;

    // Coordinate selectors.
    localparam logic [2:0] CI_AX0 = 3'd0;
    localparam logic [2:0] CI_AY0 = 3'd1;
    localparam logic [2:0] CI_AX1 = 3'd2;
    localparam logic [2:0] CI_AY1 = 3'd3;
    localparam logic [2:0] CI_BX0 = 3'd4;
    localparam logic [2:0] CI_BY0 = 3'd5;
    localparam logic [2:0] CI_BX1 = 3'd6;
    localparam logic [2:0] CI_BY1 = 3'd7;

    // Product register file slots.
    localparam logic [RF_AW-1:0] R_C1  = 4'd0;
    localparam logic [RF_AW-1:0] R_C2  = 4'd1;
    localparam logic [RF_AW-1:0] R_C3  = 4'd2;
    localparam logic [RF_AW-1:0] R_C4  = 4'd3;
    localparam logic [RF_AW-1:0] R_LA  = 4'd4;
    localparam logic [RF_AW-1:0] R_LB  = 4'd5;
    localparam logic [RF_AW-1:0] R_DA0 = 4'd6;
    localparam logic [RF_AW-1:0] R_DA1 = 4'd7;
    localparam logic [RF_AW-1:0] R_DB0 = 4'd8;
    localparam logic [RF_AW-1:0] R_DB1 = 4'd9;
    localparam logic [RF_AW-1:0] R_E00 = 4'd10;
    localparam logic [RF_AW-1:0] R_E01 = 4'd11;
    localparam logic [RF_AW-1:0] R_E10 = 4'd12;
    localparam logic [RF_AW-1:0] R_E11 = 4'd13;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_a_x0;
        logic signed [COORD_W-1:0] seg_a_y0;
        logic signed [COORD_W-1:0] seg_a_x1;
        logic signed [COORD_W-1:0] seg_a_y1;
        logic signed [COORD_W-1:0] seg_b_x0;
        logic signed [COORD_W-1:0] seg_b_y0;
        logic signed [COORD_W-1:0] seg_b_x1;
        logic signed [COORD_W-1:0] seg_b_y1;
        logic                      last_pair;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_distance;
        logic              is_touching;
    } result_t;

    typedef struct packed {
        logic [CROSS_TOL_W-1:0] cross_tol;
        logic [COORD_TOL_W-1:0] coord_tol;
        logic [ZT_W-1:0]        zero_thresh;
    } cfg_t;

    // near[0]: b0 inside box of a, near[1]: b1 in a, near[2]: a0 in b, near[3]: a1 in b
    typedef struct packed {
        item_t      item;
        logic [3:0] near;
    } work_t;

    typedef enum logic [2:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SQ_HI,
        ACC_SQ_MID,
        ACC_SQ_LO
    } acc_t;

    typedef struct packed {
        logic [2:0]       p1;
        logic [2:0]       m1;
        logic [2:0]       p2;
        logic [2:0]       m2;
        acc_t             acc;
        logic [RF_AW-1:0] dst;
    } uop_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OPS,
        BK_CLASS,
        BK_SEL,
        BK_SQ,
        BK_ROOT,
        BK_FOLD,
        BK_UPD
    } back_state_t;

    // Product pass: each step multiplies (c[p1]-c[m1]) by (c[p2]-c[m2]).
    function automatic uop_t uop_rom(input logic [OP_CW-1:0] idx);
        uop_t u;
        begin
            case (idx)
                5'd0:  u = '{CI_AX1, CI_AX0, CI_BY0, CI_AY0, ACC_LOAD, R_C1};
                5'd1:  u = '{CI_AY1, CI_AY0, CI_BX0, CI_AX0, ACC_SUB,  R_C1};
                5'd2:  u = '{CI_AX1, CI_AX0, CI_BY1, CI_AY0, ACC_LOAD, R_C2};
                5'd3:  u = '{CI_AY1, CI_AY0, CI_BX1, CI_AX0, ACC_SUB,  R_C2};
                5'd4:  u = '{CI_BX1, CI_BX0, CI_AY0, CI_BY0, ACC_LOAD, R_C3};
                5'd5:  u = '{CI_BY1, CI_BY0, CI_AX0, CI_BX0, ACC_SUB,  R_C3};
                5'd6:  u = '{CI_BX1, CI_BX0, CI_AY1, CI_BY0, ACC_LOAD, R_C4};
                5'd7:  u = '{CI_BY1, CI_BY0, CI_AX1, CI_BX0, ACC_SUB,  R_C4};
                5'd8:  u = '{CI_AX1, CI_AX0, CI_AX1, CI_AX0, ACC_LOAD, R_LA};
                5'd9:  u = '{CI_AY1, CI_AY0, CI_AY1, CI_AY0, ACC_ADD,  R_LA};
                5'd10: u = '{CI_BX1, CI_BX0, CI_BX1, CI_BX0, ACC_LOAD, R_LB};
                5'd11: u = '{CI_BY1, CI_BY0, CI_BY1, CI_BY0, ACC_ADD,  R_LB};
                5'd12: u = '{CI_AX0, CI_BX0, CI_BX1, CI_BX0, ACC_LOAD, R_DA0};
                5'd13: u = '{CI_AY0, CI_BY0, CI_BY1, CI_BY0, ACC_ADD,  R_DA0};
                5'd14: u = '{CI_AX1, CI_BX0, CI_BX1, CI_BX0, ACC_LOAD, R_DA1};
                5'd15: u = '{CI_AY1, CI_BY0, CI_BY1, CI_BY0, ACC_ADD,  R_DA1};
                5'd16: u = '{CI_BX0, CI_AX0, CI_AX1, CI_AX0, ACC_LOAD, R_DB0};
                5'd17: u = '{CI_BY0, CI_AY0, CI_AY1, CI_AY0, ACC_ADD,  R_DB0};
                5'd18: u = '{CI_BX1, CI_AX0, CI_AX1, CI_AX0, ACC_LOAD, R_DB1};
                5'd19: u = '{CI_BY1, CI_AY0, CI_AY1, CI_AY0, ACC_ADD,  R_DB1};
                5'd20: u = '{CI_AX0, CI_BX0, CI_AX0, CI_BX0, ACC_LOAD, R_E00};
                5'd21: u = '{CI_AY0, CI_BY0, CI_AY0, CI_BY0, ACC_ADD,  R_E00};
                5'd22: u = '{CI_AX0, CI_BX1, CI_AX0, CI_BX1, ACC_LOAD, R_E01};
                5'd23: u = '{CI_AY0, CI_BY1, CI_AY0, CI_BY1, ACC_ADD,  R_E01};
                5'd24: u = '{CI_AX1, CI_BX0, CI_AX1, CI_BX0, ACC_LOAD, R_E10};
                5'd25: u = '{CI_AY1, CI_BY0, CI_AY1, CI_BY0, ACC_ADD,  R_E10};
                5'd26: u = '{CI_AX1, CI_BX1, CI_AX1, CI_BX1, ACC_LOAD, R_E11};
                5'd27: u = '{CI_AY1, CI_BY1, CI_AY1, CI_BY1, ACC_ADD,  R_E11};
                default: u = '{CI_AX0, CI_AX0, CI_AX0, CI_AX0, ACC_LOAD, R_C1};
            endcase
            return u;
        end
    endfunction

endpackage

>>> src/segment_pair_min_distance.sv
// Top level of the segment pair distance block: config registers and wiring.
// Depends on spmd_pkg, spmd_front, spmd_back and spmd_outq.
//
// Usage: push one word per segment pair (two 2D segments, signed Q16.16)
// while full is low. The block folds each pair distance into a running
// minimum; on a pair with last_pair set it queues one result word
// (min_distance in Q17.16, is_touching) and clears the minimum. Take results
// with pop while empty is low; the oldest result sits on the result port.
// Configuration: write cross_tol, coord_tol, zero_thresh through cfg_valid /
// cfg_index / cfg_data (cfg_ready is always high) while the block is idle.
// Processing: pairs are processed one at a time. A pair that crosses or
// touches runs 28 products through the shared 34x34 multiplier plus
// pipeline drain, classify and update. Otherwise each of the four endpoint
// tests adds a select, three squaring products in the interior case, 33 root
// steps in the one-bit-per-cycle root unit, and a fold.
// Reset: all queues empty, config registers zero, running minimum at its maximum.
// Stall: a two-entry input queue keeps accepting while the back end works; a
// two-entry result queue holds results, and the back end holds on a last
// pair when it is full.
module segment_pair_min_distance (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spmd_pkg::item_t            item,
    input  logic                       push,
    output logic                       full,
    output spmd_pkg::result_t          result,
    output logic                       empty,
    input  logic                       pop,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [spmd_pkg::CFG_AW-1:0] cfg_index,
    input  logic [spmd_pkg::CFG_DW-1:0] cfg_data
);

    spmd_pkg::cfg_t    cfg_reg, cfg_next;
    spmd_pkg::work_t   wk;
    logic              wk_valid, wk_take;
    spmd_pkg::result_t res;
    logic              res_valid, res_ready;

    assign cfg_ready = 1'b1;

    // Register writes; drop writes to unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                spmd_pkg::CFG_CROSS_TOL:
                    cfg_next.cross_tol = cfg_data[spmd_pkg::CROSS_TOL_W-1:0];
                spmd_pkg::CFG_COORD_TOL:
                    cfg_next.coord_tol = cfg_data[spmd_pkg::COORD_TOL_W-1:0];
                spmd_pkg::CFG_ZERO_THRESH:
                    cfg_next.zero_thresh = cfg_data[spmd_pkg::ZT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .coord_tol (cfg_reg.coord_tol),
        .wk        (wk),
        .wk_valid  (wk_valid),
        .wk_take   (wk_take)
    );

    spmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wk          (wk),
        .wk_valid    (wk_valid),
        .wk_take     (wk_take),
        .cross_tol   (cfg_reg.cross_tol),
        .zero_thresh (cfg_reg.zero_thresh),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    spmd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (res),
        .wr_valid (res_valid),
        .wr_ready (res_ready),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

>>> src/spmd_front.sv
// Front end: takes input words, runs the on-segment box checks, queues work.
// Depends on spmd_pkg.
module spmd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spmd_pkg::item_t                 item,
    input  logic                            push,
    output logic                            full,
    input  logic [spmd_pkg::COORD_TOL_W-1:0] coord_tol,
    output spmd_pkg::work_t                 wk,
    output logic                            wk_valid,
    input  logic                            wk_take
);

    spmd_pkg::work_t ent_reg [2];
    spmd_pkg::work_t wr_word;
    logic            wr_reg, wr_next;
    logic            rd_reg, rd_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            do_push;

    // Point inside the segment's bounding box widened by the slack.
    function automatic logic in_box(
        input logic signed [spmd_pkg::COORD_W-1:0] v,
        input logic signed [spmd_pkg::COORD_W-1:0] a,
        input logic signed [spmd_pkg::COORD_W-1:0] b,
        input logic [spmd_pkg::COORD_TOL_W-1:0]    t
    );
        logic signed [spmd_pkg::COORD_W+1:0] ve, ae, be, lo, hi, te;
        begin
            ve = (spmd_pkg::COORD_W+2)'(v);
            ae = (spmd_pkg::COORD_W+2)'(a);
            be = (spmd_pkg::COORD_W+2)'(b);
            te = $signed({{(spmd_pkg::COORD_W+2-spmd_pkg::COORD_TOL_W){1'b0}}, t});
            lo = (ae < be) ? ae : be;
            hi = (ae < be) ? be : ae;
            return (ve >= lo - te) && (ve <= hi + te);
        end
    endfunction

    always_comb
    begin
        wr_word.item    = item;
        wr_word.near[0] = in_box(item.seg_b_x0, item.seg_a_x0, item.seg_a_x1, coord_tol)
                       && in_box(item.seg_b_y0, item.seg_a_y0, item.seg_a_y1, coord_tol);
        wr_word.near[1] = in_box(item.seg_b_x1, item.seg_a_x0, item.seg_a_x1, coord_tol)
                       && in_box(item.seg_b_y1, item.seg_a_y0, item.seg_a_y1, coord_tol);
        wr_word.near[2] = in_box(item.seg_a_x0, item.seg_b_x0, item.seg_b_x1, coord_tol)
                       && in_box(item.seg_a_y0, item.seg_b_y0, item.seg_b_y1, coord_tol);
        wr_word.near[3] = in_box(item.seg_a_x1, item.seg_b_x0, item.seg_b_x1, coord_tol)
                       && in_box(item.seg_a_y1, item.seg_b_y0, item.seg_b_y1, coord_tol);
    end

    assign full     = (cnt_reg == 2'd2);
    assign wk_valid = (cnt_reg != 2'd0);
    assign wk       = ent_reg[rd_reg];
    assign do_push  = push && !full;

    always_comb
    begin
        wr_next  = do_push ? !wr_reg : wr_reg;
        rd_next  = wk_take ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, wk_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_reg] <= wr_word;
        end
    end

endmodule

>>> src/spmd_back.sv
// Back end: product pass, crossing test, endpoint distances, running minimum.
// Depends on spmd_pkg.
module spmd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spmd_pkg::work_t                 wk,
    input  logic                            wk_valid,
    output logic                            wk_take,
    input  logic [spmd_pkg::CROSS_TOL_W-1:0] cross_tol,
    input  logic [spmd_pkg::ZT_W-1:0]        zero_thresh,
    output spmd_pkg::result_t               res,
    output logic                            res_valid,
    input  logic                            res_ready
);

    spmd_pkg::back_state_t state_reg, state_next;

    spmd_pkg::work_t work_reg, work_next;
    logic [spmd_pkg::OP_CW-1:0] op_cnt_reg, op_cnt_next;

    logic                       s1_v_reg, s1_v_next;
    logic [spmd_pkg::MUL_W-1:0] s1_a_reg, s1_a_next, s1_b_reg, s1_b_next;
    logic                       s1_neg_reg, s1_neg_next;
    spmd_pkg::acc_t             s1_acc_reg, s1_acc_next;
    logic [spmd_pkg::RF_AW-1:0] s1_dst_reg, s1_dst_next;

    logic                        s2_v_reg, s2_v_next;
    logic [spmd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                        s2_neg_reg, s2_neg_next;
    spmd_pkg::acc_t              s2_acc_reg, s2_acc_next;
    logic [spmd_pkg::RF_AW-1:0]  s2_dst_reg, s2_dst_next;

    logic signed [spmd_pkg::RF_W-1:0] rf_reg [spmd_pkg::RF_N];
    logic signed [spmd_pkg::RF_W-1:0] rf_next [spmd_pkg::RF_N];

    logic [1:0]                  k_reg, k_next;
    logic [1:0]                  sq_cnt_reg, sq_cnt_next;
    logic [spmd_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [spmd_pkg::RF_W-1:0]   cmag_reg, cmag_next;
    logic [spmd_pkg::DIST_W-1:0] q_reg, q_next;
    logic [spmd_pkg::ROOT_W-1:0] s_reg, s_next, u_reg, u_next, dsh_reg, dsh_next;
    logic [spmd_pkg::BIT_CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [spmd_pkg::DIST_W-1:0] dmin_reg, dmin_next;
    logic [spmd_pkg::DIST_W-1:0] rmin_reg, rmin_next;

    // shared combinational terms
    spmd_pkg::uop_t                     uop;
    logic signed [spmd_pkg::COORD_W-1:0] ca1, cb1, ca2, cb2;
    logic signed [spmd_pkg::DIFF_W-1:0]  d1, d2;
    logic [spmd_pkg::DIFF_W-1:0]         m1, m2;
    logic signed [spmd_pkg::RF_W-1:0]    pv, tp, tn;
    logic [3:0]                          gt, lt;
    logic                                hit, pipe_idle;
    logic signed [spmd_pkg::RF_W-1:0]    sel_len, sel_dot, sel_c, sel_es, sel_ee;
    logic signed [spmd_pkg::RF_W-1:0]    rf_zero;
    logic [spmd_pkg::ROOT_W-1:0]         cand;
    logic                                fit;
    logic [spmd_pkg::DIST_W-1:0]         upd_min;

    function automatic logic signed [spmd_pkg::COORD_W-1:0] coord_sel(
        input spmd_pkg::item_t it,
        input logic [2:0]      idx
    );
        logic signed [spmd_pkg::COORD_W-1:0] v;
        begin
            case (idx)
                spmd_pkg::CI_AX0: v = it.seg_a_x0;
                spmd_pkg::CI_AY0: v = it.seg_a_y0;
                spmd_pkg::CI_AX1: v = it.seg_a_x1;
                spmd_pkg::CI_AY1: v = it.seg_a_y1;
                spmd_pkg::CI_BX0: v = it.seg_b_x0;
                spmd_pkg::CI_BY0: v = it.seg_b_y0;
                spmd_pkg::CI_BX1: v = it.seg_b_x1;
                spmd_pkg::CI_BY1: v = it.seg_b_y1;
                default:          v = it.seg_a_x0;
            endcase
            return v;
        end
    endfunction

    assign pipe_idle = !s1_v_reg && !s2_v_reg;
    assign rf_zero   = '0;

    // Operand differences for the product pass.
    always_comb
    begin
        uop = spmd_pkg::uop_rom(op_cnt_reg);
        ca1 = coord_sel(work_reg.item, uop.p1);
        cb1 = coord_sel(work_reg.item, uop.m1);
        ca2 = coord_sel(work_reg.item, uop.p2);
        cb2 = coord_sel(work_reg.item, uop.m2);
        d1  = spmd_pkg::DIFF_W'(ca1) - spmd_pkg::DIFF_W'(cb1);
        d2  = spmd_pkg::DIFF_W'(ca2) - spmd_pkg::DIFF_W'(cb2);
        m1  = d1[spmd_pkg::DIFF_W-1] ? spmd_pkg::DIFF_W'(-d1) : spmd_pkg::DIFF_W'(d1);
        m2  = d2[spmd_pkg::DIFF_W-1] ? spmd_pkg::DIFF_W'(-d2) : spmd_pkg::DIFF_W'(d2);
        pv  = s2_neg_reg ? -$signed(spmd_pkg::RF_W'(prod_reg))
                         : $signed(spmd_pkg::RF_W'(prod_reg));
    end

    // Crossing and touch test on the four cross products.
    always_comb
    begin
        tp = $signed(spmd_pkg::RF_W'(cross_tol));
        tn = -tp;
        for (int i = 0; i < 4; i++)
        begin
            gt[i] = rf_reg[i] > tp;
            lt[i] = rf_reg[i] < tn;
        end
        hit = (((gt[0] && lt[1]) || (lt[0] && gt[1]))
            && ((gt[2] && lt[3]) || (lt[2] && gt[3])))
            || (!gt[0] && !lt[0] && work_reg.near[0])
            || (!gt[1] && !lt[1] && work_reg.near[1])
            || (!gt[2] && !lt[2] && work_reg.near[2])
            || (!gt[3] && !lt[3] && work_reg.near[3]);
    end

    // Operands of the current endpoint test.
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                sel_len = rf_reg[spmd_pkg::R_LB];  sel_dot = rf_reg[spmd_pkg::R_DA0];
                sel_c   = rf_reg[spmd_pkg::R_C3];  sel_es  = rf_reg[spmd_pkg::R_E00];
                sel_ee  = rf_reg[spmd_pkg::R_E01];
            end
            2'd1:
            begin
                sel_len = rf_reg[spmd_pkg::R_LB];  sel_dot = rf_reg[spmd_pkg::R_DA1];
                sel_c   = rf_reg[spmd_pkg::R_C4];  sel_es  = rf_reg[spmd_pkg::R_E10];
                sel_ee  = rf_reg[spmd_pkg::R_E11];
            end
            2'd2:
            begin
                sel_len = rf_reg[spmd_pkg::R_LA];  sel_dot = rf_reg[spmd_pkg::R_DB0];
                sel_c   = rf_reg[spmd_pkg::R_C1];  sel_es  = rf_reg[spmd_pkg::R_E00];
                sel_ee  = rf_reg[spmd_pkg::R_E10];
            end
            default:
            begin
                sel_len = rf_reg[spmd_pkg::R_LA];  sel_dot = rf_reg[spmd_pkg::R_DB1];
                sel_c   = rf_reg[spmd_pkg::R_C2];  sel_es  = rf_reg[spmd_pkg::R_E01];
                sel_ee  = rf_reg[spmd_pkg::R_E11];
            end
        endcase
        cand    = s_reg + u_reg + dsh_reg;
        fit     = cand <= spmd_pkg::ROOT_W'(num_reg);
        upd_min = (dmin_reg < rmin_reg) ? dmin_reg : rmin_reg;
        if (upd_min <= spmd_pkg::DIST_W'(zero_thresh))
        begin
            upd_min = '0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spmd_pkg::BK_IDLE:
                if (wk_valid) state_next = spmd_pkg::BK_OPS;
            spmd_pkg::BK_OPS:
                if (op_cnt_reg == spmd_pkg::OP_CW'(spmd_pkg::NUM_OPS) && pipe_idle)
                    state_next = spmd_pkg::BK_CLASS;
            spmd_pkg::BK_CLASS:
                state_next = hit ? spmd_pkg::BK_UPD : spmd_pkg::BK_SEL;
            spmd_pkg::BK_SEL:
                if (sel_len != rf_zero && sel_dot > rf_zero && sel_dot < sel_len)
                    state_next = spmd_pkg::BK_SQ;
                else
                    state_next = spmd_pkg::BK_ROOT;
            spmd_pkg::BK_SQ:
                if (sq_cnt_reg == 2'd3 && pipe_idle) state_next = spmd_pkg::BK_ROOT;
            spmd_pkg::BK_ROOT:
                if (bit_cnt_reg == spmd_pkg::BIT_CW'(1)) state_next = spmd_pkg::BK_FOLD;
            spmd_pkg::BK_FOLD:
                state_next = (k_reg == 2'd3) ? spmd_pkg::BK_UPD : spmd_pkg::BK_SEL;
            spmd_pkg::BK_UPD:
                if (!work_reg.item.last_pair || res_ready) state_next = spmd_pkg::BK_IDLE;
            default:
                state_next = spmd_pkg::BK_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        wk_take          = (state_reg == spmd_pkg::BK_IDLE) && wk_valid;
        res_valid        = (state_reg == spmd_pkg::BK_UPD) && work_reg.item.last_pair
                           && res_ready;
        res.min_distance = upd_min;
        res.is_touching  = (upd_min == '0);
    end

    // Datapath.
    always_comb
    begin
        work_next    = work_reg;
        op_cnt_next  = op_cnt_reg;
        s1_v_next    = 1'b0;
        s1_a_next    = s1_a_reg;
        s1_b_next    = s1_b_reg;
        s1_neg_next  = s1_neg_reg;
        s1_acc_next  = s1_acc_reg;
        s1_dst_next  = s1_dst_reg;
        s2_v_next    = s1_v_reg;
        prod_next    = s1_a_reg * s1_b_reg;
        s2_neg_next  = s1_neg_reg;
        s2_acc_next  = s1_acc_reg;
        s2_dst_next  = s1_dst_reg;
        rf_next      = rf_reg;
        k_next       = k_reg;
        sq_cnt_next  = sq_cnt_reg;
        num_next     = num_reg;
        cmag_next    = cmag_reg;
        q_next       = q_reg;
        s_next       = s_reg;
        u_next       = u_reg;
        dsh_next     = dsh_reg;
        bit_cnt_next = bit_cnt_reg;
        dmin_next    = dmin_reg;
        rmin_next    = rmin_reg;

        // write back the product in flight
        if (s2_v_reg)
        begin
            case (s2_acc_reg)
                spmd_pkg::ACC_LOAD:   rf_next[s2_dst_reg] = pv;
                spmd_pkg::ACC_ADD:    rf_next[s2_dst_reg] = rf_reg[s2_dst_reg] + pv;
                spmd_pkg::ACC_SUB:    rf_next[s2_dst_reg] = rf_reg[s2_dst_reg] - pv;
                spmd_pkg::ACC_SQ_HI:
                    num_next = num_reg + (spmd_pkg::NUM_W'(prod_reg) << spmd_pkg::SQ_HI_SH);
                spmd_pkg::ACC_SQ_MID:
                    num_next = num_reg + (spmd_pkg::NUM_W'(prod_reg) << spmd_pkg::SQ_MID_SH);
                spmd_pkg::ACC_SQ_LO:
                    num_next = num_reg + spmd_pkg::NUM_W'(prod_reg);
                default: ;
            endcase
        end

        case (state_reg)
            spmd_pkg::BK_IDLE:
            begin
                if (wk_valid)
                begin
                    work_next   = wk;
                    op_cnt_next = '0;
                end
            end
            spmd_pkg::BK_OPS:
            begin
                if (op_cnt_reg != spmd_pkg::OP_CW'(spmd_pkg::NUM_OPS))
                begin
                    s1_v_next   = 1'b1;
                    s1_a_next   = spmd_pkg::MUL_W'(m1);
                    s1_b_next   = spmd_pkg::MUL_W'(m2);
                    s1_neg_next = d1[spmd_pkg::DIFF_W-1] ^ d2[spmd_pkg::DIFF_W-1];
                    s1_acc_next = uop.acc;
                    s1_dst_next = uop.dst;
                    op_cnt_next = op_cnt_reg + 1'b1;
                end
            end
            spmd_pkg::BK_CLASS:
            begin
                dmin_next = hit ? '0 : spmd_pkg::DIST_ONES;
                k_next    = '0;
            end
            spmd_pkg::BK_SEL:
            begin
                // start the root unit; interior case squares |cross| first
                if (sel_len == rf_zero || sel_dot <= rf_zero)
                begin
                    num_next = spmd_pkg::NUM_W'(unsigned'(sel_es));
                    dsh_next = spmd_pkg::ROOT_W'(1) << spmd_pkg::ROOT_SH;
                end
                else if (sel_dot >= sel_len)
                begin
                    num_next = spmd_pkg::NUM_W'(unsigned'(sel_ee));
                    dsh_next = spmd_pkg::ROOT_W'(1) << spmd_pkg::ROOT_SH;
                end
                else
                begin
                    num_next  = '0;
                    dsh_next  = spmd_pkg::ROOT_W'(unsigned'(sel_len)) << spmd_pkg::ROOT_SH;
                    cmag_next = sel_c[spmd_pkg::RF_W-1] ? spmd_pkg::RF_W'(-sel_c)
                                                        : spmd_pkg::RF_W'(sel_c);
                end
                sq_cnt_next  = '0;
                q_next       = '0;
                s_next       = '0;
                u_next       = '0;
                bit_cnt_next = spmd_pkg::BIT_CW'(spmd_pkg::DIST_W);
            end
            spmd_pkg::BK_SQ:
            begin
                if (sq_cnt_reg != 2'd3)
                begin
                    s1_v_next   = 1'b1;
                    s1_neg_next = 1'b0;
                    s1_dst_next = '0;
                    s1_a_next   = (sq_cnt_reg == 2'd2)
                                ? spmd_pkg::MUL_W'(cmag_reg[spmd_pkg::MUL_W-1:0])
                                : spmd_pkg::MUL_W'(cmag_reg[spmd_pkg::RF_W-1:spmd_pkg::MUL_W]);
                    s1_b_next   = (sq_cnt_reg == 2'd0)
                                ? spmd_pkg::MUL_W'(cmag_reg[spmd_pkg::RF_W-1:spmd_pkg::MUL_W])
                                : spmd_pkg::MUL_W'(cmag_reg[spmd_pkg::MUL_W-1:0]);
                    case (sq_cnt_reg)
                        2'd0:    s1_acc_next = spmd_pkg::ACC_SQ_HI;
                        2'd1:    s1_acc_next = spmd_pkg::ACC_SQ_MID;
                        default: s1_acc_next = spmd_pkg::ACC_SQ_LO;
                    endcase
                    sq_cnt_next = sq_cnt_reg + 1'b1;
                end
            end
            spmd_pkg::BK_ROOT:
            begin
                // one quotient bit per cycle: keep q*q*den <= num
                if (fit)
                begin
                    s_next = cand;
                    u_next = (u_reg + (dsh_reg << 1)) >> 1;
                end
                else
                begin
                    u_next = u_reg >> 1;
                end
                dsh_next     = dsh_reg >> 2;
                q_next       = {q_reg[spmd_pkg::DIST_W-2:0], fit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
            spmd_pkg::BK_FOLD:
            begin
                if (q_reg < dmin_reg) dmin_next = q_reg;
                k_next = k_reg + 1'b1;
            end
            spmd_pkg::BK_UPD:
            begin
                if (!work_reg.item.last_pair)
                    rmin_next = upd_min;
                else if (res_ready)
                    rmin_next = spmd_pkg::DIST_ONES;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spmd_pkg::BK_IDLE;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            rmin_reg  <= spmd_pkg::DIST_ONES;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            rmin_reg  <= rmin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        op_cnt_reg  <= op_cnt_next;
        s1_a_reg    <= s1_a_next;
        s1_b_reg    <= s1_b_next;
        s1_neg_reg  <= s1_neg_next;
        s1_acc_reg  <= s1_acc_next;
        s1_dst_reg  <= s1_dst_next;
        prod_reg    <= prod_next;
        s2_neg_reg  <= s2_neg_next;
        s2_acc_reg  <= s2_acc_next;
        s2_dst_reg  <= s2_dst_next;
        rf_reg      <= rf_next;
        k_reg       <= k_next;
        sq_cnt_reg  <= sq_cnt_next;
        num_reg     <= num_next;
        cmag_reg    <= cmag_next;
        q_reg       <= q_next;
        s_reg       <= s_next;
        u_reg       <= u_next;
        dsh_reg     <= dsh_next;
        bit_cnt_reg <= bit_cnt_next;
        dmin_reg    <= dmin_next;
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wk_take |-> state_reg == spmd_pkg::BK_IDLE)
        else $error("work taken while busy");
    a_res_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> work_reg.item.last_pair && res_ready)
        else $error("result on a pair not marked last");
    a_root_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spmd_pkg::BK_ROOT |-> !s1_v_reg && !s2_v_reg)
        else $error("root step with products still in flight");
    a_rmin_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> rmin_reg == spmd_pkg::DIST_ONES)
        else $error("running minimum not cleared after result");
`endif

endmodule

>>> src/spmd_outq.sv
// Two-entry result queue between the back end and the result port.
// Depends on spmd_pkg.
module spmd_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  spmd_pkg::result_t wr_data,
    input  logic              wr_valid,
    output logic              wr_ready,
    output spmd_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    spmd_pkg::result_t ent_reg [2];
    logic              wr_reg, wr_next;
    logic              rd_reg, rd_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign result   = ent_reg[rd_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = pop && !empty;

    always_comb
    begin
        wr_next  = do_wr ? !wr_reg : wr_reg;
        rd_next  = do_rd ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ent_reg[wr_reg] <= wr_data;
        end
    end

endmodule

>>> tb/sv/segment_pair_min_distance_test.sv
// Testbench for segment_pair_min_distance: queue-style driver and checker.
// Predicts each set minimum with exact wide arithmetic; depends on spmd_pkg.
`timescale 1ns / 1ps

module segment_pair_min_distance_test;

    typedef logic signed [255:0] wide_t;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE       = 600;
    localparam int HOLD_CYCLES  = 3000;

    // Index past the last register; writes to it must change nothing.
    localparam logic [spmd_pkg::CFG_AW-1:0] CFG_SPARE = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    spmd_pkg::item_t             item = '0;
    logic                        push = 1'b0;
    logic                        full;
    spmd_pkg::result_t           result;
    logic                        empty;
    logic                        pop = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [spmd_pkg::CFG_AW-1:0] cfg_index = spmd_pkg::CFG_CROSS_TOL;
    logic [spmd_pkg::CFG_DW-1:0] cfg_data = '0;

    segment_pair_min_distance dut (
        .clk(clk), .rst_n(rst_n), .item(item), .push(push), .full(full),
        .result(result), .empty(empty), .pop(pop), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers.
    longint                      tol_cross = 0;
    longint                      tol_coord = 0;
    longint                      thresh_zero = 0;
    logic [spmd_pkg::DIST_W-1:0] set_min = spmd_pkg::DIST_ONES;

    spmd_pkg::item_t   pending_pairs[$];
    spmd_pkg::result_t expected_minima[$];

    int  mismatches = 0;
    int  minima_checked = 0;
    int  pairs_sent = 0;
    int  touching_seen = 0;
    int  full_seen = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  pop_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  calm = 1'b0;

    // Clock and reset.
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Exact distance predictor
    // ---------------------------------------------------------------
    function automatic wide_t wx(input longint v);
        wide_t r;
        r = v;
        return r;
    endfunction

    // Cross product of (b-a) and (c-a).
    function automatic wide_t turn(input longint ax, input longint ay, input longint bx,
                                   input longint by, input longint cx, input longint cy);
        return wx(bx - ax) * wx(cy - ay) - wx(by - ay) * wx(cx - ax);
    endfunction

    // Largest q with q*q*den <= num, q held to 33 bits.
    function automatic longint root_floor(input wide_t num, input wide_t den);
        longint q;
        longint c;
        wide_t  cw;
        q = 0;
        for (int b = 32; b >= 0; b--)
        begin
            c  = q | (longint'(1) << b);
            cw = wx(c);
            if (cw * cw * den <= num)
                q = c;
        end
        return q;
    endfunction

    function automatic bit spans(input longint v, input longint a, input longint b);
        longint lo;
        longint hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo - tol_coord) && (v <= hi + tol_coord);
    endfunction

    function automatic bit lies_on(input longint px, input longint py, input longint ax,
                                   input longint ay, input longint bx, input longint by);
        wide_t c;
        c = turn(ax, ay, bx, by, px, py);
        return (c <= wx(tol_cross)) && (c >= -wx(tol_cross))
            && spans(px, ax, bx) && spans(py, ay, by);
    endfunction

    function automatic bit split(input wide_t p, input wide_t q);
        wide_t tp;
        tp = wx(tol_cross);
        return (p > tp && q < -tp) || (p < -tp && q > tp);
    endfunction

    // Floor distance from point p to segment a-b, clamped to the ends.
    function automatic longint point_gap(input longint px, input longint py, input longint ax,
                                         input longint ay, input longint bx, input longint by);
        longint vx;
        longint vy;
        longint qx;
        longint qy;
        wide_t  len2;
        wide_t  dot;
        wide_t  c;
        vx   = bx - ax;
        vy   = by - ay;
        qx   = px - ax;
        qy   = py - ay;
        len2 = wx(vx) * wx(vx) + wx(vy) * wx(vy);
        dot  = wx(qx) * wx(vx) + wx(qy) * wx(vy);
        if (len2 == 0 || dot <= 0)
            return root_floor(wx(qx) * wx(qx) + wx(qy) * wx(qy), wx(1));
        if (dot >= len2)
            return root_floor(wx(px - bx) * wx(px - bx) + wx(py - by) * wx(py - by), wx(1));
        c = wx(vx) * wx(qy) - wx(vy) * wx(qx);
        return root_floor(c * c, len2);
    endfunction

    function automatic longint pair_gap(input spmd_pkg::item_t it);
        longint ax0;
        longint ay0;
        longint ax1;
        longint ay1;
        longint bx0;
        longint by0;
        longint bx1;
        longint by1;
        longint d;
        longint e;
        bit     hit;
        ax0 = it.seg_a_x0; ay0 = it.seg_a_y0; ax1 = it.seg_a_x1; ay1 = it.seg_a_y1;
        bx0 = it.seg_b_x0; by0 = it.seg_b_y0; bx1 = it.seg_b_x1; by1 = it.seg_b_y1;
        hit = split(turn(ax0, ay0, ax1, ay1, bx0, by0), turn(ax0, ay0, ax1, ay1, bx1, by1))
           && split(turn(bx0, by0, bx1, by1, ax0, ay0), turn(bx0, by0, bx1, by1, ax1, ay1));
        hit = hit || lies_on(bx0, by0, ax0, ay0, ax1, ay1)
                  || lies_on(bx1, by1, ax0, ay0, ax1, ay1)
                  || lies_on(ax0, ay0, bx0, by0, bx1, by1)
                  || lies_on(ax1, ay1, bx0, by0, bx1, by1);
        if (hit)
            return 0;
        d = point_gap(ax0, ay0, bx0, by0, bx1, by1);
        e = point_gap(ax1, ay1, bx0, by0, bx1, by1); if (e < d) d = e;
        e = point_gap(bx0, by0, ax0, ay0, ax1, ay1); if (e < d) d = e;
        e = point_gap(bx1, by1, ax0, ay0, ax1, ay1); if (e < d) d = e;
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    function automatic logic signed [31:0] edge_val();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    // One random pair; most are clustered so that touches, clamps and
    // near misses are common, a few are wild or at the range limits.
    function automatic spmd_pkg::item_t make_pair(input bit last);
        spmd_pkg::item_t it;
        int              mode;
        int              sc;
        int              cx;
        int              cy;
        logic [31:0]     dx;
        logic [31:0]     dy;
        mode = $urandom_range(0, 11);
        case ($urandom_range(0, 3))
            0:       sc = 16;
            1:       sc = 1 << 12;
            2:       sc = 1 << 18;
            default: sc = 1 << 26;
        endcase
        cx = $signed($urandom) >>> 2;
        cy = $signed($urandom) >>> 2;
        it.seg_a_x0 = cx + $urandom_range(0, 2 * sc) - sc;
        it.seg_a_y0 = cy + $urandom_range(0, 2 * sc) - sc;
        it.seg_a_x1 = cx + $urandom_range(0, 2 * sc) - sc;
        it.seg_a_y1 = cy + $urandom_range(0, 2 * sc) - sc;
        it.seg_b_x0 = cx + $urandom_range(0, 2 * sc) - sc;
        it.seg_b_y0 = cy + $urandom_range(0, 2 * sc) - sc;
        it.seg_b_x1 = cx + $urandom_range(0, 2 * sc) - sc;
        it.seg_b_y1 = cy + $urandom_range(0, 2 * sc) - sc;
        it.last_pair = last;
        case (mode)
            0:
            begin
                it.seg_a_x0 = $urandom; it.seg_a_y0 = $urandom;
                it.seg_a_x1 = $urandom; it.seg_a_y1 = $urandom;
                it.seg_b_x0 = $urandom; it.seg_b_y0 = $urandom;
                it.seg_b_x1 = $urandom; it.seg_b_y1 = $urandom;
            end
            1:
            begin
                // shared endpoint
                it.seg_b_x0 = it.seg_a_x1;
                it.seg_b_y0 = it.seg_a_y1;
            end
            2:
            begin
                // b0 at the midpoint of a, exactly on it
                dx = $urandom_range(0, sc);
                dy = $urandom_range(0, sc);
                it.seg_a_x1 = it.seg_a_x0 + 2 * dx;
                it.seg_a_y1 = it.seg_a_y0 + 2 * dy;
                it.seg_b_x0 = it.seg_a_x0 + dx;
                it.seg_b_y0 = it.seg_a_y0 + dy;
            end
            3:
            begin
                it.seg_a_x1 = it.seg_a_x0;
                it.seg_a_y1 = it.seg_a_y0;
            end
            4:
            begin
                it.seg_b_x1 = it.seg_b_x0;
                it.seg_b_y1 = it.seg_b_y0;
                if ($urandom_range(0, 1))
                begin
                    it.seg_a_x1 = it.seg_a_x0;
                    it.seg_a_y1 = it.seg_a_y0;
                end
            end
            5:
            begin
                // collinear, overlapping or apart
                dx = $urandom_range(1, 64);
                dy = $urandom_range(0, 64);
                it.seg_a_x1 = it.seg_a_x0 + 4 * dx;
                it.seg_a_y1 = it.seg_a_y0 + 4 * dy;
                it.seg_b_x0 = it.seg_a_x0 + $urandom_range(0, 8) * dx;
                it.seg_b_y0 = it.seg_a_y0 + (it.seg_b_x0 - it.seg_a_x0) / dx * dy;
                it.seg_b_x1 = it.seg_b_x0 + 2 * dx;
                it.seg_b_y1 = it.seg_b_y0 + 2 * dy;
            end
            6:
            begin
                it.seg_a_x0 = edge_val(); it.seg_a_y0 = edge_val();
                it.seg_a_x1 = edge_val(); it.seg_a_y1 = edge_val();
                it.seg_b_x0 = edge_val(); it.seg_b_y0 = edge_val();
                it.seg_b_x1 = edge_val(); it.seg_b_y1 = edge_val();
            end
            7:
            begin
                // near miss just off an endpoint
                it.seg_b_x0 = it.seg_a_x1 + $urandom_range(0, 6) - 3;
                it.seg_b_y0 = it.seg_a_y1 + $urandom_range(0, 6) - 3;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic spmd_pkg::item_t pair_of(input int ax0, input int ay0, input int ax1,
                                                input int ay1, input int bx0, input int by0,
                                                input int bx1, input int by1, input bit last);
        spmd_pkg::item_t it;
        it = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, last};
        return it;
    endfunction

    // Queue well-formed sets with a little noise mixed in.
    task automatic queue_sets(input int n, input bit all_last);
        int len;
        int k;
        k = 0;
        while (k < n)
        begin
            len = all_last ? 1 : $urandom_range(1, 5);
            for (int j = 0; j < len; j++)
            begin
                if (!all_last && $urandom_range(0, 19) == 0)
                    pending_pairs.push_back(make_pair($urandom_range(0, 1)));
                else
                    pending_pairs.push_back(make_pair(j == len - 1));
                k++;
            end
        end
    endtask

    // Hold until every word is sent and every minimum is back, then let the
    // back end finish any pair that makes no result.
    task automatic wait_idle();
        while (pending_pairs.size() != 0 || push || expected_minima.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [spmd_pkg::CFG_AW-1:0] idx,
                           input logic [spmd_pkg::CFG_DW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic cfg_set(input logic [31:0] ct, input logic [31:0] co, input logic [31:0] zt);
        cfg_put(spmd_pkg::CFG_CROSS_TOL, ct);
        cfg_put(spmd_pkg::CFG_COORD_TOL, co);
        cfg_put(spmd_pkg::CFG_ZERO_THRESH, zt);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register shadow: follow every accepted write
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == spmd_pkg::CFG_CROSS_TOL)
                tol_cross = cfg_data;
            else if (cfg_index == spmd_pkg::CFG_COORD_TOL)
                tol_coord = cfg_data[spmd_pkg::COORD_TOL_W-1:0];
            else if (cfg_index == spmd_pkg::CFG_ZERO_THRESH)
                thresh_zero = cfg_data[spmd_pkg::ZT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Driver: offer pending pairs, fold accepted ones into the minimum
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        longint            d;
        spmd_pkg::result_t r;
        if (rst_n)
        begin
            if (full)
                full_seen++;
            if (push && !full)
            begin
                d = pair_gap(item);
                if (d < longint'(set_min))
                    set_min = d;
                if (longint'(set_min) <= thresh_zero)
                    set_min = '0;
                if (item.last_pair)
                begin
                    r.min_distance = set_min;
                    r.is_touching  = (set_min == 0);
                    expected_minima.push_back(r);
                    set_min = spmd_pkg::DIST_ONES;
                end
                void'(pending_pairs.pop_front());
                pairs_sent++;
                send_gap = rand_gap();
            end
            // advance to the next word, or idle through the gap
            if (push && !full || !push)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    push <= 1'b1;
                    item <= pending_pairs[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Long receiver hold-off, started once on request
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (hold_req && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check each popped word against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        spmd_pkg::result_t exp_word;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                minima_checked++;
                if (result.is_touching)
                    touching_seen++;
                if (expected_minima.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: min_distance=%h is_touching=%b",
                                 result.min_distance, result.is_touching);
                end
                else
                begin
                    exp_word = expected_minima.pop_front();
                    if (result.min_distance !== exp_word.min_distance
                        || result.is_touching !== exp_word.is_touching)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: min_distance exp %h got %h, is_touching exp %b got %b",
                                     exp_word.min_distance, result.min_distance,
                                     exp_word.is_touching, result.is_touching);
                    end
                end
            end
            // hold off while the long stall runs, else random stalls
            if (hold_left > 0 || (hold_req && !hold_done))
            begin
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                pop_gap = rand_gap();
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Directed pairs at reset configuration.
        calm = 1'b1;
        pending_pairs.push_back(pair_of(0, 0, 100, 100, 0, 100, 100, 0, 1));        // proper cross
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 100, 0, 200, 50, 1));         // shared end
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 50, 0, 50, 80, 1));           // T touch
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 50, 0, 150, 0, 1));           // collinear overlap
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 200, 0, 300, 0, 1));          // collinear apart
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 0, 7, 100, 7, 1));            // parallel
        pending_pairs.push_back(pair_of(5, 5, 5, 5, 9, 8, 9, 8, 1));                // two points
        pending_pairs.push_back(pair_of(5, 5, 5, 5, 0, 0, 10, 0, 1));               // point over segment
        pending_pairs.push_back(pair_of(0, 0, 10, 0, -30, 4, -20, 9, 1));           // clamp before start
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 30, 4, 40, 9, 1));             // clamp past end
        pending_pairs.push_back(pair_of(0, 0, 3, 1, 1, 2, 2, 5, 1));                // floor of root
        pending_pairs.push_back(pair_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff, 1));         // widest gap
        pending_pairs.push_back(pair_of(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h8000_0000, 1));
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 0, 50, 10, 50, 0));            // set of three
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 0, 20, 10, 20, 0));
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 0, 90, 10, 90, 1));
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 5, -5, 5, 5, 0));              // zero then far
        pending_pairs.push_back(pair_of(0, 0, 10, 0, 0, 900, 10, 900, 1));
        wait_idle();

        // Tolerances: touch within slack, threshold forcing, unknown index.
        cfg_set(32'd50, 32'hffff_0003, 32'h0001_0005);
        cfg_put(CFG_SPARE, 32'hdead_beef);
        cfg_valid <= 1'b0;
        @(posedge clk);
        calm = 1'b0;
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 102, 0, 200, 40, 1));
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 50, 6, 50, 80, 1));
        pending_pairs.push_back(pair_of(0, 0, 100, 0, 0, 5, 100, 5, 1));
        queue_sets(280, 1'b0);
        wait_idle();

        // Largest settings.
        cfg_set(32'hffff_ffff, 32'h0000_ffff, 32'h0000_ffff);
        queue_sets(200, 1'b0);
        wait_idle();

        // Receiver holds off while every pair closes a set: queues fill.
        cfg_set(32'd0, 32'd0, 32'd0);
        hold_req = 1'b1;
        queue_sets(60, 1'b1);
        wait_idle();

        // Middle settings, then back to zero.
        cfg_set(32'h0001_0000, 32'h0000_0100, 32'h0000_0040);
        queue_sets(250, 1'b0);
        wait_idle();

        cfg_set(32'd0, 32'd0, 32'd0);
        calm = 1'b1;
        queue_sets(60, 1'b0);
        wait_idle();
        calm = 1'b0;
        queue_sets(180, 1'b0);
        wait_idle();

        if (expected_minima.size() != 0)
            mismatches++;
        $display("covered %0d pairs and %0d set minima (%0d touching) over five settings,",
                 pairs_sent, minima_checked, touching_seen);
        $display("input stalled by full on %0d cycles, %0d mismatches", full_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
